@@ design/abi_pkg.sv @@
// Shared types, constants and coefficient tables of the Adams-Bashforth integrator.
package abi_pkg;

    localparam int VALUE_W  = 32;
    localparam int PIDX_W   = 10;
    localparam int COMP_W   = 2;
    localparam int ORDER_W  = 3;
    localparam int STEP_W   = 32;
    localparam int SUM_W    = 48;
    localparam int WEIGHT_W = 16;
    localparam int DEN_W    = 11;
    localparam int AVG_W    = 40;
    localparam int AVG_HALF = AVG_W / 2;
    localparam int DIV_BITS = 6;
    localparam int DIV_CYCLES = SUM_W / DIV_BITS;
    localparam int FRAC_W   = 16;

    localparam logic CMD_LOAD    = 1'b0;
    localparam logic CMD_ADVANCE = 1'b1;

    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_ORDER = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_SIZE = 1'b1;

    localparam logic [ORDER_W-1:0] MAX_ORDER_RESET = 3'd4;
    localparam logic [STEP_W-1:0]  STEP_SIZE_RESET = 32'd65536;
    localparam logic [ORDER_W-1:0] STEPS_MAX       = 3'd6;

    typedef logic signed [VALUE_W-1:0] value_t;

    typedef struct packed {
        logic                 start;
        logic [ORDER_W-1:0]   order;
        logic [ORDER_W-1:0]   head;
        value_t               value;
    } hist_req_t;

    typedef struct packed {
        logic    done;
        value_t  position;
        logic    saturated;
    } scale_res_t;

    function automatic logic signed [WEIGHT_W-1:0] ab_weight(
        input logic [ORDER_W-1:0] order,
        input logic [ORDER_W-1:0] k
    );
        logic signed [WEIGHT_W-1:0] w;
        w = '0;
        case (order)
            3'd1:
            begin
                case (k)
                    3'd0: w = 16'sd1;
                    default: w = '0;
                endcase
            end
            3'd2:
            begin
                case (k)
                    3'd0: w = 16'sd3;
                    3'd1: w = -16'sd1;
                    default: w = '0;
                endcase
            end
            3'd3:
            begin
                case (k)
                    3'd0: w = 16'sd23;
                    3'd1: w = -16'sd16;
                    3'd2: w = 16'sd5;
                    default: w = '0;
                endcase
            end
            3'd4:
            begin
                case (k)
                    3'd0: w = 16'sd55;
                    3'd1: w = -16'sd59;
                    3'd2: w = 16'sd37;
                    3'd3: w = -16'sd9;
                    default: w = '0;
                endcase
            end
            3'd5:
            begin
                case (k)
                    3'd0: w = 16'sd1901;
                    3'd1: w = -16'sd2774;
                    3'd2: w = 16'sd2616;
                    3'd3: w = -16'sd1274;
                    3'd4: w = 16'sd251;
                    default: w = '0;
                endcase
            end
            3'd6:
            begin
                case (k)
                    3'd0: w = 16'sd4277;
                    3'd1: w = -16'sd7923;
                    3'd2: w = 16'sd9982;
                    3'd3: w = -16'sd7298;
                    3'd4: w = 16'sd2877;
                    3'd5: w = -16'sd475;
                    default: w = '0;
                endcase
            end
            default: w = '0;
        endcase
        return w;
    endfunction

    function automatic logic [DEN_W-1:0] ab_den(input logic [ORDER_W-1:0] order);
        logic [DEN_W-1:0] d;
        case (order)
            3'd2: d = 11'd2;
            3'd3: d = 11'd12;
            3'd4: d = 11'd24;
            3'd5: d = 11'd720;
            3'd6: d = 11'd1440;
            default: d = 11'd1;
        endcase
        return d;
    endfunction

endpackage

@@ design/abi_if.sv @@
// Item and result channel interfaces of the integrator.
interface abi_item_if;
    import abi_pkg::*;

    logic                valid;
    logic                ready;
    logic                command;
    logic [PIDX_W-1:0]   particle_index;
    logic [COMP_W-1:0]   component;
    logic signed [VALUE_W-1:0] value;
    logic                end_of_step;

    modport source (
        output valid, command, particle_index, component, value, end_of_step,
        input  ready
    );
    modport sink (
        input  valid, command, particle_index, component, value, end_of_step,
        output ready
    );
endinterface

interface abi_result_if;
    import abi_pkg::*;

    logic                valid;
    logic                ready;
    logic [PIDX_W-1:0]   particle_index_res;
    logic [COMP_W-1:0]   component_res;
    logic signed [VALUE_W-1:0] position;
    logic [ORDER_W-1:0]  order_used;
    logic                saturated;

    modport source (
        output valid, particle_index_res, component_res, position, order_used, saturated,
        input  ready
    );
    modport sink (
        input  valid, particle_index_res, component_res, position, order_used, saturated,
        output ready
    );
endinterface

@@ design/abi_hist.sv @@
// Derivative history memory and weighted history sum.
module abi_hist #(
    parameter int HISTORY_DEPTH = 6,
    parameter int SLOTS         = 3072
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  abi_pkg::hist_req_t                  req,
    input  logic [((SLOTS > 1) ? $clog2(SLOTS) : 1)-1:0] slot,
    output logic                                done,
    output logic signed [abi_pkg::SUM_W-1:0]    sum
);
    import abi_pkg::*;

    localparam int SLOT_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int ENTRIES = HISTORY_DEPTH * SLOTS;
    localparam int HADDR_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam logic [ORDER_W:0] HD_EXT = (ORDER_W + 1)'(HISTORY_DEPTH);

    value_t hist_mem [ENTRIES];

    logic                  busy_reg;
    logic                  issue_reg;
    logic                  rd_v_reg;
    logic                  prod_v_reg;
    logic [ORDER_W-1:0]    k_reg;
    logic [ORDER_W-1:0]    order_reg;
    logic [ORDER_W-1:0]    head_reg;
    logic [ORDER_W-1:0]    rd_k_reg;
    logic [SLOT_W-1:0]     slot_reg;
    value_t                rd_data_reg;
    logic signed [SUM_W-1:0] prod_reg;
    logic signed [SUM_W-1:0] acc_reg;

    logic [ORDER_W:0]      sel_sum;
    logic [ORDER_W-1:0]    sel;
    logic [HADDR_W-1:0]    raddr;
    logic [HADDR_W-1:0]    waddr;

    function automatic logic signed [SUM_W-1:0] weigh(
        input logic signed [WEIGHT_W-1:0] w,
        input value_t v
    );
        return SUM_W'(w) * SUM_W'(v);
    endfunction

    always_comb
    begin
        sel_sum = {1'b0, head_reg} + {1'b0, k_reg};
        if (sel_sum >= HD_EXT)
        begin
            sel_sum = sel_sum - HD_EXT;
        end
        sel   = sel_sum[ORDER_W-1:0];
        raddr = HADDR_W'(32'(sel) * SLOTS + 32'(slot_reg));
        waddr = HADDR_W'(32'(req.head) * SLOTS + 32'(slot));
    end

    assign done = busy_reg && !issue_reg && !rd_v_reg && !prod_v_reg;
    assign sum  = acc_reg;

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            hist_mem[waddr] <= req.value;
        end
        if (issue_reg)
        begin
            rd_data_reg <= hist_mem[raddr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg   <= 1'b0;
            issue_reg  <= 1'b0;
            rd_v_reg   <= 1'b0;
            prod_v_reg <= 1'b0;
        end
        else if (req.start)
        begin
            busy_reg   <= 1'b1;
            issue_reg  <= (req.order > 3'd1);
            rd_v_reg   <= 1'b0;
            prod_v_reg <= 1'b1;
        end
        else if (busy_reg)
        begin
            if (issue_reg && (k_reg == order_reg - 3'd1))
            begin
                issue_reg <= 1'b0;
            end
            rd_v_reg   <= issue_reg;
            prod_v_reg <= rd_v_reg;
            if (done)
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            k_reg     <= 3'd1;
            order_reg <= req.order;
            head_reg  <= req.head;
            slot_reg  <= slot;
            acc_reg   <= '0;
            prod_reg  <= weigh(ab_weight(req.order, 3'd0), req.value);
        end
        else
        begin
            if (issue_reg)
            begin
                k_reg    <= k_reg + 3'd1;
                rd_k_reg <= k_reg;
            end
            if (rd_v_reg)
            begin
                prod_reg <= weigh(ab_weight(order_reg, rd_k_reg), rd_data_reg);
            end
            if (prod_v_reg)
            begin
                acc_reg <= acc_reg + prod_reg;
            end
        end
    end

endmodule

@@ design/abi_div.sv @@
// Radix-2 restoring divider of the history sum by the order's denominator.
module abi_div (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic signed [abi_pkg::SUM_W-1:0]  sum,
    input  logic [abi_pkg::ORDER_W-1:0]       order,
    output logic                              done,
    output logic signed [abi_pkg::AVG_W-1:0]  avg
);
    import abi_pkg::*;

    localparam int CNT_W = (DIV_CYCLES > 1) ? $clog2(DIV_CYCLES) : 1;

    logic               busy_reg;
    logic               done_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic [SUM_W-1:0]   work_reg;
    logic [DEN_W-1:0]   rem_reg;
    logic [DEN_W-1:0]   den_reg;
    logic               neg_reg;

    logic [SUM_W-1:0]   work_next;
    logic [DEN_W-1:0]   rem_next;
    logic [DEN_W:0]     trial;
    logic [AVG_W-1:0]   quot;

    // DIV_BITS quotient bits per cycle; remainder stays below the denominator
    always_comb
    begin
        work_next = work_reg;
        rem_next  = rem_reg;
        trial     = '0;
        for (int i = 0; i < DIV_BITS; i++)
        begin
            trial     = {rem_next, work_next[SUM_W-1]};
            work_next = {work_next[SUM_W-2:0], 1'b0};
            if (trial >= {1'b0, den_reg})
            begin
                trial        = trial - {1'b0, den_reg};
                work_next[0] = 1'b1;
            end
            rem_next = trial[DEN_W-1:0];
        end
    end

    assign quot = work_reg[AVG_W-1:0];
    assign avg  = neg_reg ? -$signed(quot) : $signed(quot);
    assign done = done_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(DIV_CYCLES - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            work_reg <= sum[SUM_W-1] ? SUM_W'(-sum) : SUM_W'(sum);
            rem_reg  <= '0;
            den_reg  <= ab_den(order);
            neg_reg  <= sum[SUM_W-1];
        end
        else if (busy_reg)
        begin
            work_reg <= work_next;
            rem_reg  <= rem_next;
        end
    end

endmodule

@@ design/abi_scale.sv @@
// Step-size scaling in two partial products, position update and saturation.
module abi_scale (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic signed [abi_pkg::AVG_W-1:0]  avg,
    input  abi_pkg::value_t                   pos,
    input  logic [abi_pkg::STEP_W-1:0]        step_size,
    output abi_pkg::scale_res_t               res
);
    import abi_pkg::*;

    localparam int PP_W  = STEP_W + AVG_HALF + 2;
    localparam int ACC_W = STEP_W + AVG_W + 1;
    localparam int RES_W = ACC_W - FRAC_W + 1;

    typedef enum logic [4:0] {
        SC_IDLE = 5'b00001,
        SC_LO   = 5'b00010,
        SC_HI   = 5'b00100,
        SC_ACC  = 5'b01000,
        SC_SAT  = 5'b10000
    } sc_state_t;

    sc_state_t               state_reg;
    sc_state_t               state_next;
    logic                    done_reg;

    logic signed [AVG_W-1:0] avg_reg;
    value_t                  pos_reg;
    logic [STEP_W-1:0]       step_reg;
    logic signed [PP_W-1:0]  p_reg;
    logic signed [ACC_W-1:0] acc_reg;
    value_t                  position_reg;
    logic                    sat_reg;

    logic signed [STEP_W:0]     mul_a;
    logic signed [AVG_HALF:0]   mul_b;
    logic signed [PP_W-1:0]     pp;
    logic signed [RES_W-1:0]    upd;
    logic [RES_W-VALUE_W:0]     upd_top;

    always_comb
    begin
        mul_a = $signed({1'b0, step_reg});
        if (state_reg == SC_LO)
        begin
            mul_b = $signed({1'b0, avg_reg[AVG_HALF-1:0]});
        end
        else
        begin
            mul_b = $signed({avg_reg[AVG_W-1], avg_reg[AVG_W-1:AVG_HALF]});
        end
        pp      = PP_W'(mul_a) * PP_W'(mul_b);
        upd     = RES_W'(pos_reg) + RES_W'(acc_reg >>> FRAC_W);
        upd_top = upd[RES_W-1:VALUE_W-1];
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            SC_IDLE: if (start) state_next = SC_LO;
            SC_LO:   state_next = SC_HI;
            SC_HI:   state_next = SC_ACC;
            SC_ACC:  state_next = SC_SAT;
            SC_SAT:  state_next = SC_IDLE;
            default: state_next = SC_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= SC_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= (state_reg == SC_SAT);
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            SC_IDLE:
            begin
                if (start)
                begin
                    avg_reg  <= avg;
                    pos_reg  <= pos;
                    step_reg <= step_size;
                end
            end
            SC_LO:
            begin
                p_reg <= pp;
            end
            SC_HI:
            begin
                acc_reg <= ACC_W'(p_reg);
                p_reg   <= pp;
            end
            SC_ACC:
            begin
                acc_reg <= acc_reg + (ACC_W'(p_reg) <<< AVG_HALF);
            end
            SC_SAT:
            begin
                if ((upd_top != '0) && (upd_top != '1))
                begin
                    sat_reg      <= 1'b1;
                    position_reg <= upd[RES_W-1] ? $signed({1'b1, {(VALUE_W-1){1'b0}}})
                                                 : $signed({1'b0, {(VALUE_W-1){1'b1}}});
                end
                else
                begin
                    sat_reg      <= 1'b0;
                    position_reg <= upd[VALUE_W-1:0];
                end
            end
            default:
            begin
            end
        endcase
    end

    assign res.done      = done_reg;
    assign res.position  = position_reg;
    assign res.saturated = sat_reg;

endmodule

@@ design/adams_bashforth_integrator.sv @@
// Top level of the Adams-Bashforth particle integrator.
// Items arrive on the item channel (valid/ready); each gives exactly one
// transaction on the result channel, in order. A load writes the coordinate
// and returns it with order_used 0. An advance stores the derivative as the
// newest history word, forms the weighted history sum (one history read a
// cycle), divides it by the order's denominator (6 quotient bits a cycle),
// scales by step_size in two partial products and saturates the new position.
// One item is in work at a time: the next one is accepted in the cycle after
// the result register is loaded. The result register holds a finished
// transaction while the receiver stalls; the next item is accepted meanwhile
// and waits at its end until the register is taken.
// Reset clears the step counter, history head and registers (max_order 4,
// step_size 1.0); position and history memories are undefined until written.
// Configuration is a plain write port; the user must write it only while
// idle, and the block itself has no guard for it.
module adams_bashforth_integrator #(
    parameter int PARTICLES     = 1024,
    parameter int HISTORY_DEPTH = 6,
    parameter int COMPONENTS    = 3
) (
    input  logic                              clk,
    input  logic                              rst_n,
    abi_item_if.sink                          item,
    abi_result_if.source                      result,
    input  logic                              cfg_we,
    input  logic [abi_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [abi_pkg::STEP_W-1:0]        cfg_data
);
    import abi_pkg::*;

    localparam int SLOTS  = PARTICLES * COMPONENTS;
    localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam logic [ORDER_W-1:0] HD_ORDER = ORDER_W'(HISTORY_DEPTH);
    localparam logic [ORDER_W-1:0] HD_LAST  = ORDER_W'(HISTORY_DEPTH - 1);

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_FETCH = 6'b000010,
        ST_SUM   = 6'b000100,
        ST_DIV   = 6'b001000,
        ST_SCALE = 6'b010000,
        ST_DONE  = 6'b100000
    } state_t;

    state_t                 state_reg;
    state_t                 state_next;

    logic [ORDER_W-1:0]     max_order_reg;
    logic [STEP_W-1:0]      step_size_reg;
    logic [ORDER_W-1:0]     head_reg;
    logic [ORDER_W-1:0]     steps_reg;
    logic                   out_valid_reg;

    logic [PIDX_W-1:0]      pidx_reg;
    logic [COMP_W-1:0]      comp_reg;
    logic                   eos_reg;
    value_t                 value_reg;
    logic [SLOT_W-1:0]      slot_reg;
    value_t                 res_pos_reg;
    logic [ORDER_W-1:0]     res_order_reg;
    logic                   res_sat_reg;
    logic [PIDX_W-1:0]      out_pidx_reg;
    logic [COMP_W-1:0]      out_comp_reg;
    value_t                 out_pos_reg;
    logic [ORDER_W-1:0]     out_order_reg;
    logic                   out_sat_reg;

    value_t                 pos_mem [SLOTS];
    value_t                 pos_rd_reg;

    logic                   accept;
    logic                   in_range;
    logic [SLOT_W-1:0]      in_slot;
    logic [ORDER_W-1:0]     max_clamped;
    logic [ORDER_W-1:0]     steps_plus;
    logic [ORDER_W-1:0]     order_now;
    logic                   out_free;
    logic                   pos_we;
    logic [SLOT_W-1:0]      pos_waddr;
    value_t                 pos_wdata;

    hist_req_t              hist_req;
    logic                   hist_done;
    logic signed [SUM_W-1:0] hist_sum;
    logic                   div_start;
    logic                   div_done;
    logic signed [AVG_W-1:0] div_avg;
    logic                   scale_start;
    scale_res_t             scale_res;

    assign item.ready = (state_reg == ST_IDLE);
    assign accept     = item.valid && item.ready;
    assign out_free   = !out_valid_reg || result.ready;

    always_comb
    begin
        in_range = (32'(item.particle_index) < PARTICLES) &&
                   (32'(item.component) < COMPONENTS);
        in_slot  = SLOT_W'(32'(item.particle_index) * COMPONENTS + 32'(item.component));

        max_clamped = max_order_reg;
        if (max_order_reg == '0)
        begin
            max_clamped = 3'd1;
        end
        else if (max_order_reg > HD_ORDER)
        begin
            max_clamped = HD_ORDER;
        end
        steps_plus = steps_reg + 3'd1;
        order_now  = (steps_plus > max_clamped) ? max_clamped : steps_plus;
    end

    assign hist_req.start = (state_reg == ST_FETCH);
    assign hist_req.order = order_now;
    assign hist_req.head  = head_reg;
    assign hist_req.value = value_reg;
    assign div_start      = (state_reg == ST_SUM) && hist_done;
    assign scale_start    = (state_reg == ST_DIV) && div_done;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = (in_range && (item.command == CMD_ADVANCE)) ? ST_FETCH
                                                                              : ST_DONE;
                end
            end
            ST_FETCH: state_next = ST_SUM;
            ST_SUM:   if (hist_done) state_next = ST_DIV;
            ST_DIV:   if (div_done) state_next = ST_SCALE;
            ST_SCALE: if (scale_res.done) state_next = ST_DONE;
            ST_DONE:  if (out_free) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            max_order_reg <= MAX_ORDER_RESET;
            step_size_reg <= STEP_SIZE_RESET;
            head_reg      <= '0;
            steps_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_MAX_ORDER: max_order_reg <= cfg_data[ORDER_W-1:0];
                    CFG_STEP_SIZE: step_size_reg <= cfg_data;
                    default: ;
                endcase
            end
            if ((state_reg == ST_SCALE) && scale_res.done && eos_reg)
            begin
                head_reg <= (head_reg == '0) ? HD_LAST : head_reg - 3'd1;
                if (steps_reg < STEPS_MAX)
                begin
                    steps_reg <= steps_reg + 3'd1;
                end
            end
            if ((state_reg == ST_DONE) && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            pidx_reg      <= item.particle_index;
            comp_reg      <= item.component;
            eos_reg       <= item.end_of_step;
            value_reg     <= item.value;
            slot_reg      <= in_slot;
            res_pos_reg   <= in_range ? item.value : '0;
            res_order_reg <= '0;
            res_sat_reg   <= 1'b0;
        end
        if (state_reg == ST_FETCH)
        begin
            res_order_reg <= order_now;
        end
        if ((state_reg == ST_SCALE) && scale_res.done)
        begin
            res_pos_reg <= scale_res.position;
            res_sat_reg <= scale_res.saturated;
        end
        if ((state_reg == ST_DONE) && out_free)
        begin
            out_pidx_reg  <= pidx_reg;
            out_comp_reg  <= comp_reg;
            out_pos_reg   <= res_pos_reg;
            out_order_reg <= res_order_reg;
            out_sat_reg   <= res_sat_reg;
        end
    end

    always_comb
    begin
        pos_we    = (accept && in_range && (item.command == CMD_LOAD)) ||
                    ((state_reg == ST_SCALE) && scale_res.done);
        pos_waddr = (state_reg == ST_SCALE) ? slot_reg : in_slot;
        pos_wdata = (state_reg == ST_SCALE) ? scale_res.position : item.value;
    end

    always_ff @(posedge clk)
    begin
        if (pos_we)
        begin
            pos_mem[pos_waddr] <= pos_wdata;
        end
        if (state_reg == ST_FETCH)
        begin
            pos_rd_reg <= pos_mem[slot_reg];
        end
    end

    abi_hist #(
        .HISTORY_DEPTH (HISTORY_DEPTH),
        .SLOTS         (SLOTS)
    ) u_hist (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (hist_req),
        .slot  (slot_reg),
        .done  (hist_done),
        .sum   (hist_sum)
    );

    abi_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .sum   (hist_sum),
        .order (res_order_reg),
        .done  (div_done),
        .avg   (div_avg)
    );

    abi_scale u_scale (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (scale_start),
        .avg       (div_avg),
        .pos       (pos_rd_reg),
        .step_size (step_size_reg),
        .res       (scale_res)
    );

    assign result.valid              = out_valid_reg;
    assign result.particle_index_res = out_pidx_reg;
    assign result.component_res      = out_comp_reg;
    assign result.position           = out_pos_reg;
    assign result.order_used         = out_order_reg;
    assign result.saturated          = out_sat_reg;

endmodule

@@ verif/testbench.sv @@
// Self-checking testbench for the Adams-Bashforth particle integrator.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import abi_pkg::*;

    localparam int PARTICLES    = 1024;
    localparam int HIST         = 6;
    localparam int COMPONENTS   = 3;
    localparam int SLOTS        = PARTICLES * COMPONENTS;
    localparam int POOL         = 12;
    localparam int HOLD_CYCLES  = 400;
    localparam int TAIL_CYCLES  = 40;
    localparam int LIMIT_CYCLES = 400000;

    localparam int AB_W [6][6] = '{
        '{1, 0, 0, 0, 0, 0},
        '{3, -1, 0, 0, 0, 0},
        '{23, -16, 5, 0, 0, 0},
        '{55, -59, 37, -9, 0, 0},
        '{1901, -2774, 2616, -1274, 251, 0},
        '{4277, -7923, 9982, -7298, 2877, -475}
    };
    localparam int AB_DEN [6] = '{1, 2, 12, 24, 720, 1440};

    localparam value_t V_MAX = 32'h7FFF_FFFF;
    localparam value_t V_MIN = 32'h8000_0000;

    typedef struct packed {
        logic                command;
        logic [PIDX_W-1:0]   pidx;
        logic [COMP_W-1:0]   comp;
        value_t              value;
        logic                eos;
    } item_t;

    typedef struct packed {
        logic [PIDX_W-1:0]   pidx;
        logic [COMP_W-1:0]   comp;
        value_t              position;
        logic [ORDER_W-1:0]  order;
        logic                sat;
    } outcome_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [STEP_W-1:0]     cfg_data;

    abi_item_if   item_ch ();
    abi_result_if res_ch ();

    adams_bashforth_integrator uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item_ch),
        .result    (res_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // integrator state as the block should hold it
    value_t              coord_mem [SLOTS];
    value_t              deriv_mem [HIST][SLOTS];
    int                  hist_head   = 0;
    int                  steps_done  = 0;
    logic [ORDER_W-1:0]  order_limit = MAX_ORDER_RESET;
    logic [STEP_W-1:0]   dt_reg      = STEP_SIZE_RESET;

    // stimulus-side tracking of which entries hold data
    bit                  g_pos_ok  [SLOTS];
    bit                  g_hist_ok [HIST][SLOTS];
    int                  g_head  = 0;
    int                  g_steps = 0;
    int                  g_max   = 4;

    item_t               pending_items [$];
    outcome_t            expected_results [$];
    item_t               offered;
    outcome_t            due;

    logic [PIDX_W-1:0]   pool_pidx [POOL];
    logic [COMP_W-1:0]   pool_comp [POOL];

    int                  send_idle   = 20;
    int                  recv_idle   = 78;
    int                  hold_asked  = 0;
    int                  hold_taken  = 0;
    int                  hold_left   = 0;
    int                  mismatches  = 0;
    int                  cycle_count = 0;

    function automatic outcome_t integrate_item(item_t it);
        outcome_t o;
        int       slot;
        int       m;
        int       n;
        int       k;
        longint   acc;
        longint   avg;
        longint   inc;
        longint   res;
        o.pidx     = it.pidx;
        o.comp     = it.comp;
        o.position = '0;
        o.order    = '0;
        o.sat      = 1'b0;
        if (int'(it.comp) < COMPONENTS && int'(it.pidx) < PARTICLES)
        begin
            slot = int'(it.pidx) * COMPONENTS + int'(it.comp);
            if (it.command == CMD_LOAD)
            begin
                coord_mem[slot] = it.value;
                o.position = it.value;
            end
            else
            begin
                m = int'(order_limit);
                if (m < 1)
                    m = 1;
                if (m > HIST)
                    m = HIST;
                n = (steps_done + 1 < m) ? steps_done + 1 : m;
                deriv_mem[hist_head][slot] = it.value;
                acc = 0;
                for (k = 0; k < n; k++)
                begin
                    acc += longint'(AB_W[n-1][k]) *
                           longint'(deriv_mem[(hist_head + k) % HIST][slot]);
                end
                avg = acc / longint'(AB_DEN[n-1]);
                inc = longint'(dt_reg[31:16]) * avg +
                      ((longint'(dt_reg[15:0]) * avg) >>> 16);
                res = longint'(coord_mem[slot]) + inc;
                if (res > longint'(V_MAX))
                begin
                    res   = longint'(V_MAX);
                    o.sat = 1'b1;
                end
                else if (res < longint'(V_MIN))
                begin
                    res   = longint'(V_MIN);
                    o.sat = 1'b1;
                end
                coord_mem[slot] = value_t'(res[31:0]);
                o.position = coord_mem[slot];
                o.order    = ORDER_W'(n);
                if (it.eos)
                begin
                    hist_head = (hist_head + HIST - 1) % HIST;
                    if (steps_done < 6)
                        steps_done++;
                end
            end
        end
        return o;
    endfunction

    // Queues one transaction; an advance that would read unwritten data
    // is turned into a load of that coordinate.
    function automatic void add_item(logic cmd, logic [PIDX_W-1:0] p, logic [COMP_W-1:0] c,
                                     value_t v, logic eos);
        item_t it;
        int    slot;
        int    n;
        int    k;
        bit    safe;
        if (int'(c) < COMPONENTS)
        begin
            slot = int'(p) * COMPONENTS + int'(c);
            if (cmd == CMD_ADVANCE)
            begin
                n = (g_steps + 1 < g_max) ? g_steps + 1 : g_max;
                safe = g_pos_ok[slot];
                for (k = 1; k < n; k++)
                begin
                    if (!g_hist_ok[(g_head + k) % HIST][slot])
                        safe = 1'b0;
                end
                if (!safe)
                    cmd = CMD_LOAD;
            end
            if (cmd == CMD_LOAD)
                g_pos_ok[slot] = 1'b1;
            else
            begin
                g_hist_ok[g_head][slot] = 1'b1;
                if (eos)
                begin
                    g_head = (g_head + HIST - 1) % HIST;
                    if (g_steps < 6)
                        g_steps++;
                end
            end
        end
        it.command = cmd;
        it.pidx    = p;
        it.comp    = c;
        it.value   = v;
        it.eos     = eos;
        pending_items.insert(pending_items.size(), it);
    endfunction

    function automatic value_t pick_value();
        value_t v;
        case ($urandom_range(7))
            0: v = value_t'($urandom);
            1: v = $urandom_range(1) ? V_MAX : V_MIN;
            2: v = $urandom_range(1) ? value_t'(0) : value_t'(-1);
            default: v = value_t'(int'($urandom_range(2097152)) - 1048576);
        endcase
        return v;
    endfunction

    // Time steps over the particle pool in shuffled order, with stray loads,
    // out-of-range items, skipped coordinates, early step ends and repeats.
    function automatic void fill_steps(int count);
        int   made;
        int   i;
        int   j;
        int   t;
        int   perm [POOL];
        logic eos_here;
        bit   twice;
        made = 0;
        while (made < count)
        begin
            for (i = 0; i < POOL; i++)
                perm[i] = i;
            for (i = POOL - 1; i > 0; i--)
            begin
                j = $urandom_range(i);
                t = perm[i];
                perm[i] = perm[j];
                perm[j] = t;
            end
            for (i = 0; i < POOL; i++)
            begin
                j = perm[i];
                if ($urandom_range(99) < 8)
                begin
                    add_item(1'($urandom_range(1)), PIDX_W'($urandom_range(1023)),
                             COMP_W'($urandom_range(3)), pick_value(),
                             1'($urandom_range(1)));
                    made++;
                end
                if ($urandom_range(99) < 4)
                begin
                    add_item(CMD_LOAD, pool_pidx[j], pool_comp[j], pick_value(), 1'b0);
                    made++;
                end
                if ($urandom_range(99) >= 4)
                begin
                    eos_here = (i == POOL - 1) || ($urandom_range(99) < 3);
                    twice    = ($urandom_range(99) < 5);
                    add_item(CMD_ADVANCE, pool_pidx[j], pool_comp[j], pick_value(),
                             twice ? 1'b0 : eos_here);
                    made++;
                    if (twice)
                    begin
                        add_item(CMD_ADVANCE, pool_pidx[j], pool_comp[j], pick_value(),
                                 eos_here);
                        made++;
                    end
                end
            end
        end
    endfunction

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [STEP_W-1:0] data);
        int mo;
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == CFG_MAX_ORDER)
        begin
            order_limit = data[ORDER_W-1:0];
            mo = int'(data[ORDER_W-1:0]);
            g_max = (mo < 1) ? 1 : ((mo > HIST) ? HIST : mo);
        end
        else
            dt_reg = data;
    endtask

    task automatic drain();
        while (pending_items.size() != 0 || item_ch.valid || expected_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic run_phase(input logic [ORDER_W-1:0] mo, input logic [STEP_W-1:0] dt,
                             input int s_idle, input int r_idle, input int count,
                             input bit hold);
        write_register(CFG_MAX_ORDER, STEP_W'(mo));
        write_register(CFG_STEP_SIZE, dt);
        send_idle <= s_idle;
        recv_idle <= r_idle;
        @(negedge clk);
        fill_steps(count);
        if (hold)
            hold_asked <= hold_asked + 1;
        drain();
    endtask

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES)
        begin
            $display("FAIL adams_bashforth_integrator");
            $finish;
        end
    end

    // driver
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (item_ch.valid && item_ch.ready)
                expected_results.insert(expected_results.size(), integrate_item(offered));
            if (!item_ch.valid || item_ch.ready)
            begin
                if (pending_items.size() != 0 && $urandom_range(99) >= send_idle)
                begin
                    offered = pending_items.pop_front();
                    item_ch.valid          <= 1'b1;
                    item_ch.command        <= offered.command;
                    item_ch.particle_index <= offered.pidx;
                    item_ch.component      <= offered.comp;
                    item_ch.value          <= offered.value;
                    item_ch.end_of_step    <= offered.eos;
                end
                else
                    item_ch.valid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (res_ch.valid && res_ch.ready)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("result transaction with none expected: index %0d axis %0d",
                           res_ch.particle_index_res, res_ch.component_res);
                    mismatches++;
                end
                else
                begin
                    due = expected_results.pop_front();
                    if (res_ch.particle_index_res !== due.pidx)
                    begin
                        $error("particle_index_res expected %0d got %0d",
                               due.pidx, res_ch.particle_index_res);
                        mismatches++;
                    end
                    if (res_ch.component_res !== due.comp)
                    begin
                        $error("component_res expected %0d got %0d",
                               due.comp, res_ch.component_res);
                        mismatches++;
                    end
                    if (res_ch.position !== due.position)
                    begin
                        $error("position expected %h got %h", due.position, res_ch.position);
                        mismatches++;
                    end
                    if (res_ch.order_used !== due.order)
                    begin
                        $error("order_used expected %0d got %0d", due.order, res_ch.order_used);
                        mismatches++;
                    end
                    if (res_ch.saturated !== due.sat)
                    begin
                        $error("saturated expected %0d got %0d", due.sat, res_ch.saturated);
                        mismatches++;
                    end
                end
            end
            if (hold_left > 0)
            begin
                res_ch.ready <= 1'b0;
                hold_left    <= hold_left - 1;
            end
            else if (hold_taken != hold_asked)
            begin
                hold_taken   <= hold_asked;
                hold_left    <= HOLD_CYCLES;
                res_ch.ready <= 1'b0;
            end
            else
                res_ch.ready <= ($urandom_range(99) >= recv_idle);
        end
    end

    initial
    begin
        int     s;
        int     i;
        value_t ramp_vals [6];
        ramp_vals = '{32'h0001_0000, 32'hFFFF_8000, V_MAX, V_MIN, 32'h0000_0001, 32'hFFFF_FFFF};
        rst_n                  = 1'b0;
        cfg_we                 = 1'b0;
        cfg_index              = '0;
        cfg_data               = '0;
        item_ch.valid          = 1'b0;
        item_ch.command        = CMD_LOAD;
        item_ch.particle_index = '0;
        item_ch.component      = '0;
        item_ch.value          = '0;
        item_ch.end_of_step    = 1'b0;
        res_ch.ready           = 1'b0;
        for (i = 0; i < POOL; i++)
        begin
            pool_pidx[i] = PIDX_W'($urandom_range(1023));
            pool_comp[i] = COMP_W'($urandom_range(2));
        end
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // directed: extremes, ignored end flag, out-of-range index, order ramp
        @(negedge clk);
        add_item(CMD_LOAD, 10'd0, 2'd0, V_MAX, 1'b0);
        add_item(CMD_LOAD, 10'd1023, 2'd2, V_MIN, 1'b0);
        add_item(CMD_LOAD, 10'd512, 2'd1, value_t'(0), 1'b0);
        add_item(CMD_LOAD, 10'd3, 2'd1, value_t'(32'h1234_5678), 1'b1);
        add_item(CMD_LOAD, 10'd1023, 2'd3, value_t'(-1), 1'b0);
        for (s = 0; s < 6; s++)
        begin
            add_item(CMD_ADVANCE, 10'd0, 2'd0, V_MAX, 1'b0);
            add_item(CMD_ADVANCE, 10'd1023, 2'd2, V_MIN, 1'b0);
            if (s == 2)
                add_item(CMD_ADVANCE, 10'd512, 2'd1, V_MIN, 1'b0);
            if (s == 3)
                add_item(CMD_ADVANCE, 10'd700, 2'd3, V_MAX, 1'b1);
            add_item(CMD_ADVANCE, 10'd512, 2'd1, ramp_vals[s], 1'b1);
        end
        drain();

        @(negedge clk);
        for (i = 0; i < POOL; i++)
            add_item(CMD_LOAD, pool_pidx[i], pool_comp[i], pick_value(), 1'b0);
        drain();

        run_phase(3'd1, 32'h0001_0000, 20, 78, 150, 1'b0);
        run_phase(3'd6, 32'hFFFF_FFFF, 20, 78, 120, 1'b0);
        run_phase(3'd7, 32'h0000_0000, 78, 20, 120, 1'b1);
        run_phase(3'd0, $urandom, 78, 20, 100, 1'b0);
        run_phase(3'd3, 32'h0000_0001, 78, 20, 100, 1'b0);
        run_phase(3'd5, $urandom_range(32'h0004_0000), 0, 0, 150, 1'b1);
        run_phase(3'd2, 32'h0000_8000, 0, 0, 100, 1'b0);

        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("PASS adams_bashforth_integrator");
        else
            $display("FAIL adams_bashforth_integrator");
        $finish;
    end

endmodule

@@ adams_bashforth_integrator.f @@
design/abi_pkg.sv
design/abi_if.sv
design/abi_hist.sv
design/abi_div.sv
design/abi_scale.sv
design/adams_bashforth_integrator.sv
verif/testbench.sv
